// ----- hw/rtl/x86_64_instruction_encoder_defines.svh -----
// Assertion macros shared by the encoder's checker.
`ifndef X86_64_INSTRUCTION_ENCODER_DEFINES_SVH
`define X86_64_INSTRUCTION_ENCODER_DEFINES_SVH

// Concurrent assertion, ignored while reset is held.
`define XENC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that also holds across reset.
`define XENC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/xenc_pkg.sv -----
// Shared types, opcode constants and descriptor layout of the encoder.
package xenc_pkg;

    // Request kinds carried in the input tuser field.
    typedef enum logic [3:0] {
        REQ_MOV_IMM64 = 4'd0,
        REQ_MOV_RR    = 4'd1,
        REQ_ADD_RR    = 4'd2,
        REQ_ADD_IMM32 = 4'd3,
        REQ_IDIV      = 4'd4,
        REQ_IMUL      = 4'd5,
        REQ_SUB_RR    = 4'd6,
        REQ_SUB_IMM32 = 4'd7,
        REQ_RET       = 4'd8,
        REQ_XOR_RR    = 4'd9,
        REQ_XOR_IMM32 = 4'd10
    } t_req_kind;

    localparam logic [7:0] REX_BASE   = 8'b0100_0000;
    localparam logic [7:0] REX_W      = 8'h08;
    localparam logic [7:0] OP_MOV_IMM = 8'hB8;
    localparam logic [7:0] OP_MOV_RR  = 8'h8B;
    localparam logic [7:0] OP_ADD_RR  = 8'h03;
    localparam logic [7:0] OP_GRP1    = 8'h81;
    localparam logic [7:0] OP_GRP3    = 8'hF7;
    localparam logic [7:0] OP_ESC     = 8'h0F;
    localparam logic [7:0] OP_IMUL    = 8'hAF;
    localparam logic [7:0] OP_SUB_RR  = 8'h2B;
    localparam logic [7:0] OP_RET     = 8'hC3;
    localparam logic [7:0] OP_XOR_RR  = 8'h33;

    // ModRM reg-field extensions of the group opcodes.
    localparam logic [2:0] EXT_ADD  = 3'd0;
    localparam logic [2:0] EXT_SUB  = 3'd5;
    localparam logic [2:0] EXT_XOR  = 3'd6;
    localparam logic [2:0] EXT_IDIV = 3'd7;

    localparam int MAX_BYTES     = 10;
    localparam int LEN_W         = 4;
    localparam int QUEUE_DEPTH_D = 2;

    // One encoded instruction: bytes in emit order, byte 0 first.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
    } t_desc;

endpackage

// ----- hw/rtl/xenc_front.sv -----
// Front end: accepts requests, builds the byte descriptor, drops undefined kinds.
module xenc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_req_type,
    input  logic [3:0]         i_dest_reg,
    input  logic [63:0]        i_source_value,
    output logic               o_push,
    input  logic               i_push_ready,
    output xenc_pkg::t_desc    o_desc
);

    logic            r_valid;
    xenc_pkg::t_desc r_desc;
    xenc_pkg::t_desc n_desc;
    logic            w_take;

    function automatic logic [7:0] rex(input logic rbit, input logic bbit);
        rex = xenc_pkg::REX_BASE | xenc_pkg::REX_W | {5'b0, rbit, 1'b0, bbit};
    endfunction

    function automatic logic [7:0] modrm(input logic [2:0] reg_f, input logic [2:0] rm_f);
        modrm = {2'b11, reg_f, rm_f};
    endfunction

    always_comb begin
        logic [3:0] d;
        logic [3:0] s;
        d = i_dest_reg;
        s = i_source_value[3:0];
        n_desc = '0;
        unique case (i_req_type)
            xenc_pkg::REQ_MOV_IMM64: begin
                n_desc.bytes[0]   = rex(1'b0, d[3]);
                n_desc.bytes[1]   = xenc_pkg::OP_MOV_IMM | {5'b0, d[2:0]};
                n_desc.bytes[9:2] = i_source_value;
                n_desc.len        = xenc_pkg::LEN_W'(10);
            end
            xenc_pkg::REQ_MOV_RR, xenc_pkg::REQ_ADD_RR,
            xenc_pkg::REQ_SUB_RR, xenc_pkg::REQ_XOR_RR: begin
                n_desc.bytes[0] = rex(d[3], s[3]);
                priority case (i_req_type)
                    xenc_pkg::REQ_MOV_RR: n_desc.bytes[1] = xenc_pkg::OP_MOV_RR;
                    xenc_pkg::REQ_ADD_RR: n_desc.bytes[1] = xenc_pkg::OP_ADD_RR;
                    xenc_pkg::REQ_SUB_RR: n_desc.bytes[1] = xenc_pkg::OP_SUB_RR;
                    default:              n_desc.bytes[1] = xenc_pkg::OP_XOR_RR;
                endcase
                n_desc.bytes[2] = modrm(d[2:0], s[2:0]);
                n_desc.len      = xenc_pkg::LEN_W'(3);
            end
            xenc_pkg::REQ_ADD_IMM32, xenc_pkg::REQ_SUB_IMM32,
            xenc_pkg::REQ_XOR_IMM32: begin
                n_desc.bytes[0] = rex(1'b0, d[3]);
                n_desc.bytes[1] = xenc_pkg::OP_GRP1;
                priority case (i_req_type)
                    xenc_pkg::REQ_ADD_IMM32: n_desc.bytes[2] = modrm(xenc_pkg::EXT_ADD, d[2:0]);
                    xenc_pkg::REQ_SUB_IMM32: n_desc.bytes[2] = modrm(xenc_pkg::EXT_SUB, d[2:0]);
                    default:                 n_desc.bytes[2] = modrm(xenc_pkg::EXT_XOR, d[2:0]);
                endcase
                n_desc.bytes[6:3] = i_source_value[31:0];
                n_desc.len        = xenc_pkg::LEN_W'(7);
            end
            xenc_pkg::REQ_IDIV: begin
                n_desc.bytes[0] = rex(1'b0, d[3]);
                n_desc.bytes[1] = xenc_pkg::OP_GRP3;
                n_desc.bytes[2] = modrm(xenc_pkg::EXT_IDIV, d[2:0]);
                n_desc.len      = xenc_pkg::LEN_W'(3);
            end
            xenc_pkg::REQ_IMUL: begin
                n_desc.bytes[0] = rex(d[3], s[3]);
                n_desc.bytes[1] = xenc_pkg::OP_ESC;
                n_desc.bytes[2] = xenc_pkg::OP_IMUL;
                n_desc.bytes[3] = modrm(d[2:0], s[2:0]);
                n_desc.len      = xenc_pkg::LEN_W'(4);
            end
            xenc_pkg::REQ_RET: begin
                n_desc.bytes[0] = xenc_pkg::OP_RET;
                n_desc.len      = xenc_pkg::LEN_W'(1);
            end
            default: n_desc = '0;
        endcase
    end

    assign o_ready = !r_valid || i_push_ready;
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_valid;
    assign o_desc  = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            // drop undefined kinds: they encode to zero bytes
            r_valid <= (n_desc.len != '0);
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_desc <= n_desc;
        end
    end

endmodule

// ----- hw/rtl/xenc_fifo.sv -----
// Descriptor queue between front end and byte sequencer.
module xenc_fifo #(
    parameter int DEPTH = xenc_pkg::QUEUE_DEPTH_D
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  xenc_pkg::t_desc i_desc,
    output logic            o_valid,
    input  logic            i_pop,
    output xenc_pkg::t_desc o_desc
);

    localparam int AW = $clog2(DEPTH);

    xenc_pkg::t_desc r_mem [DEPTH];
    logic [AW:0]     r_wr_ptr;
    logic [AW:0]     r_rd_ptr;
    logic            w_full;
    logic            w_empty;

    assign w_empty      = (r_wr_ptr == r_rd_ptr);
    assign w_full       = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                          (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign o_push_ready = !w_full;
    assign o_valid      = !w_empty;
    assign o_desc       = r_mem[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !w_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !w_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !w_full) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_desc;
        end
    end

endmodule

// ----- hw/rtl/xenc_back.sv -----
// Back end: steps through a descriptor one byte per cycle into the output register while it is not stalled.
module xenc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_pop,
    input  xenc_pkg::t_desc i_desc,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last
);

    logic                       r_cur_valid;
    xenc_pkg::t_desc            r_cur;
    logic [xenc_pkg::LEN_W-1:0] r_idx;
    logic                       r_o_valid;
    logic [7:0]                 r_o_byte;
    logic                       r_o_last;
    logic                       w_out_free;
    logic                       w_emit;
    logic                       w_fin;

    assign w_out_free = !r_o_valid || i_ready;
    assign w_emit     = r_cur_valid && w_out_free;
    assign w_fin      = w_emit && (r_idx == r_cur.len - 1'b1);
    assign o_pop      = i_valid && (!r_cur_valid || w_fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
            end else if (w_fin) begin
                r_cur_valid <= 1'b0;
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_desc;
            r_idx <= '0;
        end else if (w_emit) begin
            r_idx <= r_idx + 1'b1;
        end
        if (w_emit) begin
            r_o_byte <= r_cur.bytes[r_idx];
            r_o_last <= w_fin;
        end
    end

    assign o_valid = r_o_valid;
    assign o_byte  = r_o_byte;
    assign o_last  = r_o_last;

endmodule

// ----- hw/rtl/x86_64_instruction_encoder.sv -----
// x86-64 encoder top level: REX/opcode/ModRM/immediate byte stream per request.
// A request passes the front-end register, the queue, the back end's descriptor register and the output register.
// Throughput: one byte per cycle while the output is not stalled; a request gives 1 to 10 bytes (its length).
// The byte-wide output register bounds the rate; the front end keeps accepting while the queue has room.
// Reset (i_rst_n low, synchronous) empties the queue and drops any word in flight.
module x86_64_instruction_encoder #(
    parameter int QUEUE_DEPTH = xenc_pkg::QUEUE_DEPTH_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // [3:0] dest_reg, [67:4] source_value, [71:68] zero
    input  logic [3:0]  i_s_axis_tuser,   // [3:0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] code_byte
    output logic        o_m_axis_tlast    // last_byte
);

    logic            w_push;
    logic            w_push_ready;
    xenc_pkg::t_desc w_front_desc;
    logic            w_q_valid;
    logic            w_q_pop;
    xenc_pkg::t_desc w_q_desc;

    // Classify each word and hold its encoded bytes in one register stage.
    xenc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_req_type     (i_s_axis_tuser),
        .i_dest_reg     (i_s_axis_tdata[3:0]),
        .i_source_value (i_s_axis_tdata[67:4]),
        .o_push         (w_push),
        .i_push_ready   (w_push_ready),
        .o_desc         (w_front_desc)
    );

    // Decouple the front end from the byte sequencer.
    xenc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_desc       (w_front_desc),
        .o_valid      (w_q_valid),
        .i_pop        (w_q_pop),
        .o_desc       (w_q_desc)
    );

    // Advance one byte per cycle while tready does not stall the output; mark the final byte with tlast.
    xenc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_pop   (w_q_pop),
        .i_desc  (w_q_desc),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// ----- hw/rtl/xenc_checker.sv -----
// Port-level checker for the encoder, bound to the top level.
`include "x86_64_instruction_encoder_defines.svh"

module xenc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    logic r_first;
    logic w_out_take;

    assign w_out_take = o_m_axis_tvalid && i_m_axis_tready;

    // Track whether the next output word opens an instruction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (w_out_take) begin
            r_first <= o_m_axis_tlast;
        end
    end

    `XENC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

    `XENC_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)), "stalled output word changed")

    `XENC_ASSERT(a_first_byte, i_clk, i_rst_n, (w_out_take && r_first) |-> (o_m_axis_tdata == xenc_pkg::OP_RET || (o_m_axis_tdata[7:4] == 4'h4 && o_m_axis_tdata[3])), "instruction does not open with REX.W or ret")

    `XENC_ASSERT(a_ret_single, i_clk, i_rst_n, (w_out_take && r_first && o_m_axis_tdata == xenc_pkg::OP_RET) |-> o_m_axis_tlast, "ret encoding longer than one byte")

endmodule

bind x86_64_instruction_encoder xenc_checker u_xenc_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the x86-64 instruction encoder byte stream.
module testbench;

    // Expected output word: one code byte and its end-of-instruction mark.
    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_code_word;

    // Holds the predicted byte stream of every accepted request, oldest first.
    class t_code_scoreboard;
        localparam logic [7:0] REX_R = 8'h04;
        localparam logic [7:0] REX_B = 8'h01;

        t_code_word pending_bytes[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function logic [7:0] rex_byte(logic r_ext, logic b_ext);
            return xenc_pkg::REX_BASE | xenc_pkg::REX_W |
                   (r_ext ? REX_R : 8'h00) | (b_ext ? REX_B : 8'h00);
        endfunction

        function logic [7:0] modrm_byte(logic [2:0] reg_field, logic [2:0] rm_field);
            return {2'b11, reg_field, rm_field};
        endfunction

        // Predict the encoding of one accepted request and queue its bytes.
        function void note_request(logic [3:0] kind, logic [3:0] dest, logic [63:0] src);
            logic [7:0] enc[$];
            logic [3:0] sreg;
            logic [2:0] grp_ext;
            int         imm_len;
            sreg    = src[3:0];
            imm_len = 0;
            grp_ext = xenc_pkg::EXT_ADD;
            case (kind)
                xenc_pkg::REQ_MOV_IMM64: begin
                    // register lives in the opcode byte, so its high bit goes to REX.B
                    enc.push_back(rex_byte(1'b0, dest[3]));
                    enc.push_back(xenc_pkg::OP_MOV_IMM | {5'b0, dest[2:0]});
                    imm_len = 8;
                end
                xenc_pkg::REQ_MOV_RR, xenc_pkg::REQ_ADD_RR,
                xenc_pkg::REQ_SUB_RR, xenc_pkg::REQ_XOR_RR: begin
                    enc.push_back(rex_byte(dest[3], sreg[3]));
                    case (kind)
                        xenc_pkg::REQ_MOV_RR: enc.push_back(xenc_pkg::OP_MOV_RR);
                        xenc_pkg::REQ_ADD_RR: enc.push_back(xenc_pkg::OP_ADD_RR);
                        xenc_pkg::REQ_SUB_RR: enc.push_back(xenc_pkg::OP_SUB_RR);
                        default:              enc.push_back(xenc_pkg::OP_XOR_RR);
                    endcase
                    enc.push_back(modrm_byte(dest[2:0], sreg[2:0]));
                end
                xenc_pkg::REQ_ADD_IMM32, xenc_pkg::REQ_SUB_IMM32,
                xenc_pkg::REQ_XOR_IMM32: begin
                    case (kind)
                        xenc_pkg::REQ_ADD_IMM32: grp_ext = xenc_pkg::EXT_ADD;
                        xenc_pkg::REQ_SUB_IMM32: grp_ext = xenc_pkg::EXT_SUB;
                        default:                 grp_ext = xenc_pkg::EXT_XOR;
                    endcase
                    enc.push_back(rex_byte(1'b0, dest[3]));
                    enc.push_back(xenc_pkg::OP_GRP1);
                    enc.push_back(modrm_byte(grp_ext, dest[2:0]));
                    imm_len = 4;
                end
                xenc_pkg::REQ_IDIV: begin
                    enc.push_back(rex_byte(1'b0, dest[3]));
                    enc.push_back(xenc_pkg::OP_GRP3);
                    enc.push_back(modrm_byte(xenc_pkg::EXT_IDIV, dest[2:0]));
                end
                xenc_pkg::REQ_IMUL: begin
                    enc.push_back(rex_byte(dest[3], sreg[3]));
                    enc.push_back(xenc_pkg::OP_ESC);
                    enc.push_back(xenc_pkg::OP_IMUL);
                    enc.push_back(modrm_byte(dest[2:0], sreg[2:0]));
                end
                xenc_pkg::REQ_RET: enc.push_back(xenc_pkg::OP_RET);
                default: ;  // undefined kinds encode to nothing
            endcase
            // immediate goes out little-endian
            for (int i = 0; i < imm_len; i++)
                enc.push_back(src[8*i +: 8]);
            foreach (enc[i])
                pending_bytes.push_back('{code: enc[i], last: (i == enc.size() - 1)});
        endfunction

        // Compare one output word against the oldest prediction.
        function void check_byte(logic [7:0] code, logic last);
            t_code_word exp_word;
            if (pending_bytes.size() == 0) begin
                $error("unexpected code byte %02h (last %0b)", code, last);
                errors++;
                return;
            end
            exp_word = pending_bytes.pop_front();
            if (code !== exp_word.code) begin
                $error("code_byte: expected %02h, got %02h", exp_word.code, code);
                errors++;
            end
            if (last !== exp_word.last) begin
                $error("last_byte: expected %0b, got %0b", exp_word.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata = '0;    // [3:0] dest_reg, [67:4] source_value, [71:68] zero
    logic [3:0]  s_tuser = '0;    // [3:0] req_type
    logic        m_tready = 1'b0;
    logic        steady = 1'b0;   // suppress idling on both sides
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;  // [7:0] code_byte
    logic        o_m_axis_tlast;

    t_code_scoreboard sb = new();

    x86_64_instruction_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Note every request word the block takes; values read here are pre-edge.
    always @(posedge i_clk) begin
        if (rst_n && s_tvalid && o_s_axis_tready)
            sb.note_request(s_tuser, s_tdata[3:0], s_tdata[67:4]);
    end

    // Check every output word taken, then pick the next ready at random unless steady is set.
    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_tready)
            sb.check_byte(o_m_axis_tdata, o_m_axis_tlast);
        m_tready <= steady || ($urandom_range(99) >= 19);
    end

    // Present one request word, with an occasional idle gap ahead of it, and hold
    // it until the block takes it.
    task automatic send_request(logic [3:0] kind, logic [3:0] dest, logic [63:0] src);
        if (!steady && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, src, dest};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Hold until every predicted byte has come out; step one edge first so the
    // last word taken is already noted.
    task automatic wait_drained();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_source();
        case ($urandom_range(5))
            0:       return 64'(0);
            1:       return '1;
            2:       return {32'($urandom), 28'($urandom), 4'($urandom_range(15))};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    initial begin
        logic [3:0] kind;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every kind, register extremes, immediate extremes.
        send_request(xenc_pkg::REQ_MOV_IMM64, 4'd0, 64'h0);
        // extended reg sets REX.B
        send_request(xenc_pkg::REQ_MOV_IMM64, 4'd8, 64'h0123_4567_89AB_CDEF);
        send_request(xenc_pkg::REQ_MOV_IMM64, 4'd15, '1);
        send_request(xenc_pkg::REQ_MOV_RR, 4'd0, 64'd15);
        // high source bits ignored
        send_request(xenc_pkg::REQ_MOV_RR, 4'd15, 64'hFFFF_FFFF_FFFF_FFF0);
        send_request(xenc_pkg::REQ_ADD_RR, 4'd7, 64'd8);
        // upper half ignored
        send_request(xenc_pkg::REQ_ADD_IMM32, 4'd0, 64'hFFFF_FFFF_0000_0000);
        send_request(xenc_pkg::REQ_ADD_IMM32, 4'd15, 64'h0000_0000_FFFF_FFFF);
        send_request(xenc_pkg::REQ_IDIV, 4'd0, '1);
        send_request(xenc_pkg::REQ_IDIV, 4'd15, 64'h0);
        send_request(xenc_pkg::REQ_IMUL, 4'd9, 64'd3);
        send_request(xenc_pkg::REQ_IMUL, 4'd2, 64'd12);
        send_request(xenc_pkg::REQ_SUB_RR, 4'd15, 64'd15);
        send_request(xenc_pkg::REQ_SUB_IMM32, 4'd11, 64'h8000_0000_8000_0000);
        send_request(xenc_pkg::REQ_RET, 4'd15, '1);
        send_request(xenc_pkg::REQ_RET, 4'd0, 64'h0);
        send_request(xenc_pkg::REQ_XOR_RR, 4'd8, 64'd0);
        send_request(xenc_pkg::REQ_XOR_IMM32, 4'd5, 64'h1234_5678_DEAD_BEEF);
        send_request(4'd11, 4'd3, '1);                               // undefined kinds: no bytes
        send_request(4'd15, 4'd15, 64'h0);
        send_request(xenc_pkg::REQ_RET, 4'd0, 64'h0);

        // Drain the pipe completely before the random part.
        s_tvalid <= 1'b0;
        wait_drained();

        for (int n = 0; n < 200; n++) begin
            steady <= (n >= 80 && n < 130);
            if ($urandom_range(99) < 5)
                kind = 4'($urandom_range(11, 15));
            else
                kind = 4'($urandom_range(0, 10));
            send_request(kind, 4'($urandom_range(15)), random_source());
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Stop a hung run.
    initial begin
        #4000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/xenc_pkg.sv
hw/rtl/xenc_front.sv
hw/rtl/xenc_fifo.sv
hw/rtl/xenc_back.sv
hw/rtl/x86_64_instruction_encoder.sv
hw/rtl/xenc_checker.sv
verif/testbench.sv
